[design/wsoe_pkg.sv]
// Shared constants, codes and the waveform table builder for the oscillator.
package wsoe_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int POS_W       = 32 + ADDR_W;

  // configuration register indexes
  localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [2:0] REG_OUTPUT_GAIN = 3'd1;
  localparam logic [2:0] REG_WT_MODE     = 3'd2;
  localparam logic [2:0] REG_ENV_RATE    = 3'd3;
  localparam logic [2:0] REG_FILT_COEFF  = 3'd4;

  // state memory entries
  localparam logic [1:0] ST_TABLE_PHASE = 2'd0;
  localparam logic [1:0] ST_SAW_PHASE   = 2'd1;
  localparam logic [1:0] ST_ENVELOPE    = 2'd2;
  localparam logic [1:0] ST_LOWPASS     = 2'd3;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Q30 sum in twentieths, halved, down to Q15
  localparam longint unsigned ROUND_DIV  = 64'd40 << 15;
  localparam longint unsigned ROUND_HALF = ROUND_DIV >> 1;

  // sin(2*pi*a/TABLE_DEPTH) in Q2.30, quarter-wave Taylor series
  function automatic longint sine_q30(int unsigned a);
    longint unsigned p, r, x, x2, t;
    logic [1:0] quad;
    p    = ({32'd0, a} << 32) / TABLE_DEPTH;
    quad = p[31:30];
    r    = p & (Q30_ONE - 64'd1);
    if (quad[0]) r = Q30_ONE - r;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    t  = (x * t) >> 30;
    return quad[1] ? -longint'(t) : longint'(t);
  endfunction

  // one table entry: 0.5*(s1 + 0.3 s2 + 0.15 s3 + 0.1 s4), Q1.15, rounded to nearest with ties away from zero
  function automatic logic signed [15:0] wave_entry(int unsigned i);
    longint sum;
    longint unsigned mag, q;
    sum = 20 * sine_q30(i % TABLE_DEPTH)
        + 6 * sine_q30((2 * i) % TABLE_DEPTH)
        + 3 * sine_q30((3 * i) % TABLE_DEPTH)
        + 2 * sine_q30((4 * i) % TABLE_DEPTH);
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    q   = (mag + ROUND_HALF) / ROUND_DIV;
    if (q > 64'd32767) q = 64'd32767;
    return (sum < 0) ? -16'(q) : 16'(q);
  endfunction

endpackage

[design/wsoe_wave_rom.sv]
// Waveform ROM, contents fixed at elaboration, one registered read per cycle.
module wsoe_wave_rom (
  input  logic                                clk,
  input  logic [wsoe_pkg::ADDR_W-1:0]         rd_addr,
  output logic signed [15:0]                  rd_data
);

  logic signed [15:0] rom [wsoe_pkg::TABLE_DEPTH];
  logic signed [15:0] rd_data_r;

  for (genvar g = 0; g < wsoe_pkg::TABLE_DEPTH; g++) begin : g_fill
    assign rom[g] = wsoe_pkg::wave_entry(g);
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/wavetable_saw_oscillator_envelope_top.sv]
// Top level: wavetable / filtered-saw oscillator with one-pole envelope.
// Each input word produces one Q1.15 sample word. A sequencer walks one item at a time through a
// four-entry state memory (both phases, envelope, lowpass level) and the waveform ROM, both read
// through a register, and a single shared multiplier. No new item is taken until the current one
// is through; wavetable mode also reads the ROM and interpolates, saw mode runs the lowpass, and
// an item with output_gain zero goes straight to the output stage, muted. A finished word
// waits in the output register while the next item is taken. Reset and clear_first mark the state
// entries invalid, so they read as zero; no clearing pass is needed.
module wavetable_saw_oscillator_envelope_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] clear_first, [7:1] zero
  input  logic        in_tlast,   // end_of_block
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic        out_tlast,  // block_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RD_ENV = 11'b00000000010,
    S_RD_PH  = 11'b00000000100,
    S_ENV    = 11'b00000001000,
    S_ROM_B  = 11'b00000010000,
    S_INTERP = 11'b00000100000,
    S_SMP    = 11'b00001000000,
    S_LP     = 11'b00010000000,
    S_LPW    = 11'b00100000000,
    S_GAIN   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] phase_step_r;
  logic [16:0] gain_r;
  logic        mode_r;
  logic [15:0] rate_r;
  logic [15:0] coeff_r;

  // state memory
  logic [31:0] st_mem [4];
  logic [3:0]  st_vld_r;
  logic [1:0]  rd_addr;
  logic [31:0] rd_data_r;
  logic        rd_vld_r;
  logic [31:0] rd_val;
  logic        wr_en;
  logic [1:0]  wr_addr;
  logic [31:0] wr_data;

  // datapath
  logic               mute_r, eob_r;
  logic [15:0]        env_r;
  logic               up_r;
  logic [31:0]        phase_r;
  logic signed [15:0] a_r;
  logic signed [15:0] lp_r;
  logic signed [51:0] mul_r, mul_nxt;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic               mul_ld;

  logic                      in_acc;
  logic                      out_ld;
  logic                      out_valid_r;
  logic [15:0]               out_data_r;
  logic                      out_last_r;

  logic [31:0]               pos_src;
  logic [wsoe_pkg::POS_W-1:0] pos;
  logic [wsoe_pkg::ADDR_W-1:0] idx, idx_next, rom_addr;
  logic signed [15:0]        rom_q;

  logic [15:0]        target;
  logic [15:0]        mag;
  logic [31:0]        step_sum;
  logic [15:0]        env_new;
  logic signed [16:0] diff;
  logic signed [15:0] saw;
  logic signed [15:0] sample;
  logic signed [15:0] lp_new;
  logic signed [19:0] prod_hi;
  logic [15:0]        result;

  wsoe_wave_rom u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign rd_val    = rd_vld_r ? rd_data_r : 32'd0;

  // table position of the phase that is current in this state
  assign pos_src  = (state_r == S_ENV) ? rd_val : phase_r;
  assign pos      = wsoe_pkg::POS_W'(pos_src) * wsoe_pkg::POS_W'(wsoe_pkg::TABLE_DEPTH);
  assign idx      = pos[wsoe_pkg::POS_W-1:32];
  assign idx_next = (idx == wsoe_pkg::ADDR_W'(wsoe_pkg::TABLE_DEPTH - 1)) ? '0 : idx + 1'b1;
  assign rom_addr = (state_r == S_ENV) ? idx : idx_next;

  assign target   = (phase_step_r != 32'd0) ? 16'hFFFF : 16'd0;
  assign mag      = (target > rd_val[15:0]) ? target - rd_val[15:0] : rd_val[15:0] - target;
  // ceil(mag*rate / 2^16); the sum stays below 2^32
  assign step_sum = mul_r[31:0] + 32'd65535;
  assign env_new  = up_r ? env_r + step_sum[31:16] : env_r - step_sum[31:16];
  assign saw      = {~phase_r[31], phase_r[30:16]};
  assign lp_new   = lp_r + mul_r[31:16];
  assign prod_hi  = mul_r[51:32];
  assign mul_nxt  = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    rd_addr   = wsoe_pkg::ST_ENVELOPE;
    wr_en     = 1'b0;
    wr_addr   = wsoe_pkg::ST_ENVELOPE;
    wr_data   = 32'd0;
    mul_a     = '0;
    mul_b     = '0;
    mul_ld    = 1'b0;
    sample    = '0;
    diff      = '0;
    out_ld    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (gain_r == 17'd0) ? S_DONE : S_RD_ENV;
      end
      S_RD_ENV: begin
        rd_addr   = wsoe_pkg::ST_ENVELOPE;
        state_nxt = S_RD_PH;
      end
      S_RD_PH: begin
        rd_addr   = mode_r ? wsoe_pkg::ST_TABLE_PHASE : wsoe_pkg::ST_SAW_PHASE;
        mul_a     = {18'd0, mag};
        mul_b     = {2'd0, rate_r};
        mul_ld    = 1'b1;
        state_nxt = S_ENV;
      end
      S_ENV: begin
        rd_addr   = wsoe_pkg::ST_LOWPASS;
        wr_en     = 1'b1;
        wr_addr   = wsoe_pkg::ST_ENVELOPE;
        wr_data   = {16'd0, env_new};
        state_nxt = mode_r ? S_ROM_B : S_LP;
      end
      S_ROM_B: begin
        wr_en     = 1'b1;
        wr_addr   = wsoe_pkg::ST_TABLE_PHASE;
        wr_data   = phase_r + phase_step_r;
        state_nxt = S_INTERP;
      end
      S_INTERP: begin
        diff      = 17'(rom_q) - 17'(a_r);
        mul_a     = {{17{diff[16]}}, diff};
        mul_b     = {2'd0, pos[31:16]};
        mul_ld    = 1'b1;
        state_nxt = S_SMP;
      end
      S_SMP: begin
        sample    = a_r + mul_r[31:16];
        mul_a     = {{18{sample[15]}}, sample};
        mul_b     = {2'd0, env_r};
        mul_ld    = 1'b1;
        state_nxt = S_GAIN;
      end
      S_LP: begin
        diff      = 17'(saw) - 17'(signed'(rd_val[15:0]));
        mul_a     = {{17{diff[16]}}, diff};
        mul_b     = {2'd0, coeff_r};
        mul_ld    = 1'b1;
        wr_en     = 1'b1;
        wr_addr   = wsoe_pkg::ST_SAW_PHASE;
        wr_data   = phase_r + phase_step_r;
        state_nxt = S_LPW;
      end
      S_LPW: begin
        wr_en     = 1'b1;
        wr_addr   = wsoe_pkg::ST_LOWPASS;
        wr_data   = {{16{lp_new[15]}}, lp_new};
        sample    = lp_new >>> 1;
        mul_a     = {{18{sample[15]}}, sample};
        mul_b     = {2'd0, env_r};
        mul_ld    = 1'b1;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        mul_a     = mul_r[33:0];
        mul_b     = {1'b0, gain_r};
        mul_ld    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // saturate floor(product / 2^32) to 16 bits; zero when the item is muted
  always_comb begin
    if (mute_r) result = 16'd0;
    else if (prod_hi > 20'sd32767) result = 16'h7FFF;
    else if (prod_hi < -20'sd32768) result = 16'h8000;
    else result = prod_hi[15:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      st_vld_r     <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_step_r <= 32'd0;
      gain_r       <= 17'd0;
      mode_r       <= 1'b1;
      rate_r       <= 16'd66;
      coeff_r      <= 16'd6554;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= st_vld_r[rd_addr];
      if (in_acc && in_tdata[0]) st_vld_r <= '0;
      else if (wr_en) st_vld_r[wr_addr] <= 1'b1;
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wsoe_pkg::REG_PHASE_STEP:  phase_step_r <= cfg_data;
          wsoe_pkg::REG_OUTPUT_GAIN: gain_r       <= cfg_data[16:0];
          wsoe_pkg::REG_WT_MODE:     mode_r       <= cfg_data[0];
          wsoe_pkg::REG_ENV_RATE:    rate_r       <= cfg_data[15:0];
          wsoe_pkg::REG_FILT_COEFF:  coeff_r      <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // state memory; the sequence never reads an entry in the cycle it is written
  always_ff @(posedge clk) begin
    if (wr_en) st_mem[wr_addr] <= wr_data;
    rd_data_r <= st_mem[rd_addr];
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mute_r <= (gain_r == 17'd0);
      eob_r  <= in_tlast;
    end
    if (state_r == S_RD_PH) begin
      env_r <= rd_val[15:0];
      up_r  <= target > rd_val[15:0];
    end
    if (state_r == S_ENV) begin
      env_r   <= env_new;
      phase_r <= rd_val;
    end
    if (state_r == S_ROM_B) a_r <= rom_q;
    if (state_r == S_LP) lp_r <= rd_val[15:0];
    if (mul_ld) mul_r <= mul_nxt;
    if (out_ld) begin
      out_data_r <= result;
      out_last_r <= eob_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[design/wsoe_checker.sv]
// Port-level checks for the oscillator top level, bound to it.
module wsoe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the item finished");

  a_word_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("output word appeared with no item at work");

endmodule

bind wavetable_saw_oscillator_envelope_top wsoe_checker u_wsoe_checker (.*);
